// ===== rtl/hse_pkg.sv =====
// heap sort engine package: sizes and shared structs
// used by hse_ram, hse_seq, heap_sort_engine and hse_checker
package hse_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  // one write port and two read ports of the heap store
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } mem_req_t;

  // one sorted result on its way to the output register
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              last;
    logic              ovf;
  } res_t;

endpackage

// ===== rtl/hse_ram.sv =====
// heap store: one write port, two registered read ports
// depends on hse_pkg
module hse_ram (
  input  logic                   clk_i,
  input  hse_pkg::mem_req_t      req_i,
  output logic [hse_pkg::DATA_W-1:0] rdata_a_o,
  output logic [hse_pkg::DATA_W-1:0] rdata_b_o
);
  import hse_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_a_o <= mem_q[req_i.raddr_a];
    rdata_b_o <= mem_q[req_i.raddr_b];
  end

endmodule

// ===== rtl/hse_seq.sv =====
// load / heapify / sort / emit sequencer around one shared signed comparator
// depends on hse_pkg, drives the hse_ram ports
module hse_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [hse_pkg::DATA_W-1:0] in_value_i,
  input  logic                       in_last_i,
  output logic                       in_ready_o,
  input  logic                       out_free_i,
  output logic                       res_push_o,
  output hse_pkg::res_t              res_o,
  output hse_pkg::mem_req_t          mem_req_o,
  input  logic [hse_pkg::DATA_W-1:0] rdata_a_i,
  input  logic [hse_pkg::DATA_W-1:0] rdata_b_i
);
  import hse_pkg::*;

  typedef enum logic [10:0] {
    S_LOAD    = 11'b000_0000_0001,
    S_BUILD   = 11'b000_0000_0010,
    S_FETCH   = 11'b000_0000_0100,
    S_LATCH   = 11'b000_0000_1000,
    S_ISSUE   = 11'b000_0001_0000,
    S_SEL     = 11'b000_0010_0000,
    S_CMP     = 11'b000_0100_0000,
    S_HEAP    = 11'b000_1000_0000,
    S_SWAP    = 11'b001_0000_0000,
    S_EMIT_RD = 11'b010_0000_0000,
    S_EMIT_WR = 11'b100_0000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              dropped_q, dropped_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0]  len_q, len_d;
  logic [DATA_W-1:0] item_q, item_d;
  logic [DATA_W-1:0] child_q, child_d;
  logic [ADDR_W-1:0] cidx_q, cidx_d;
  logic              has_right_q, has_right_d;
  logic              build_q, build_d;

  logic [CNT_W:0]    kid_w;
  logic [CNT_W:0]    right_w;
  logic [CNT_W-1:0]  idx_m1;
  logic [CNT_W-1:0]  count_inc;
  logic [DATA_W-1:0] cmp_a, cmp_b;
  logic              cmp_lt;
  state_e            ret_state;

  assign kid_w     = {1'b0, pos_q, 1'b1};
  assign right_w   = kid_w + (CNT_W+1)'(1);
  assign idx_m1    = idx_q - CNT_W'(1);
  assign count_inc = count_q + CNT_W'(1);
  assign ret_state = build_q ? S_BUILD : S_HEAP;

  // the shared compare unit
  always_comb begin
    if (state_q == S_SEL) begin
      cmp_a = rdata_a_i;
      cmp_b = rdata_b_i;
    end else begin
      cmp_a = item_q;
      cmp_b = child_q;
    end
  end
  assign cmp_lt = $signed(cmp_a) < $signed(cmp_b);

  assign in_ready_o = (state_q == S_LOAD);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    dropped_d   = dropped_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    len_d       = len_q;
    item_d      = item_q;
    child_d     = child_q;
    cidx_d      = cidx_q;
    has_right_d = has_right_q;
    build_d     = build_q;
    mem_req_o   = '0;
    res_push_o  = 1'b0;
    res_o.data  = rdata_a_i;
    res_o.last  = (idx_q + CNT_W'(1)) == count_q;
    res_o.ovf   = dropped_q;

    case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          if (count_q < CNT_W'(DEPTH)) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = count_q[ADDR_W-1:0];
            mem_req_o.wdata = in_value_i;
            count_d         = count_inc;
          end else begin
            dropped_d = 1'b1;
          end
          if (in_last_i) begin
            idx_d   = count_d >> 1;
            build_d = 1'b1;
            state_d = S_BUILD;
          end
        end
      end
      S_BUILD: begin
        if (idx_q == '0) begin
          build_d = 1'b0;
          idx_d   = count_q;
          state_d = S_HEAP;
        end else begin
          pos_d   = idx_m1[ADDR_W-1:0];
          len_d   = count_q;
          idx_d   = idx_m1;
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        mem_req_o.raddr_a = pos_q;
        state_d           = S_LATCH;
      end
      S_LATCH: begin
        item_d  = rdata_a_i;
        state_d = S_ISSUE;
      end
      S_ISSUE: begin
        if (kid_w >= {1'b0, len_q}) begin
          // leaf reached: settle the carried item here
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = pos_q;
          mem_req_o.wdata = item_q;
          state_d         = ret_state;
        end else begin
          mem_req_o.raddr_a = kid_w[ADDR_W-1:0];
          mem_req_o.raddr_b = right_w[ADDR_W-1:0];
          has_right_d       = right_w < {1'b0, len_q};
          state_d           = S_SEL;
        end
      end
      S_SEL: begin
        if (has_right_q && cmp_lt) begin
          child_d = rdata_b_i;
          cidx_d  = right_w[ADDR_W-1:0];
        end else begin
          child_d = rdata_a_i;
          cidx_d  = kid_w[ADDR_W-1:0];
        end
        state_d = S_CMP;
      end
      S_CMP: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = pos_q;
        if (cmp_lt) begin
          // larger child moves up, continue one level down
          mem_req_o.wdata = child_q;
          pos_d           = cidx_q;
          state_d         = S_ISSUE;
        end else begin
          mem_req_o.wdata = item_q;
          state_d         = ret_state;
        end
      end
      S_HEAP: begin
        if (idx_q <= CNT_W'(1)) begin
          idx_d   = '0;
          state_d = S_EMIT_RD;
        end else begin
          mem_req_o.raddr_a = '0;
          mem_req_o.raddr_b = idx_m1[ADDR_W-1:0];
          state_d           = S_SWAP;
        end
      end
      S_SWAP: begin
        // root goes to the end, old tail entry is sifted from the root
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = idx_m1[ADDR_W-1:0];
        mem_req_o.wdata = rdata_a_i;
        item_d          = rdata_b_i;
        pos_d           = '0;
        len_d           = idx_m1;
        idx_d           = idx_m1;
        state_d         = S_ISSUE;
      end
      S_EMIT_RD: begin
        mem_req_o.raddr_a = idx_q[ADDR_W-1:0];
        state_d           = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        mem_req_o.raddr_a = idx_q[ADDR_W-1:0];
        if (out_free_i) begin
          res_push_o = 1'b1;
          if (res_o.last) begin
            count_d   = '0;
            dropped_d = 1'b0;
            state_d   = S_LOAD;
          end else begin
            idx_d   = idx_q + CNT_W'(1);
            state_d = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      count_q   <= '0;
      dropped_q <= 1'b0;
      idx_q     <= '0;
      build_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
      idx_q     <= idx_d;
      build_q   <= build_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    len_q       <= len_d;
    item_q      <= item_d;
    child_q     <= child_d;
    cidx_q      <= cidx_d;
    has_right_q <= has_right_d;
  end

endmodule

// ===== rtl/heap_sort_engine.sv =====
// heap sort engine top level: stream ports, output register
// depends on hse_pkg, hse_ram, hse_seq
//
// Collects signed 32-bit values, one per slave transaction, into a 64-entry
// store; the transaction with tlast closes the set. Values arriving with the
// store full are dropped and every result of that set then carries tuser = 1.
// After the closing transaction the block drops s_axis_tready_o, heapifies
// the set in place, sorts it, and emits one master transaction per held
// value in ascending order, tlast marking the largest. Loading accepts one
// value per cycle. Sorting is done by a single sequencer that owns one
// signed comparator and a dual-read, single-write store with registered
// read data: each sift step runs child read, child select and compare
// against the carried item, each build sift adds index step, item fetch
// and item latch, and each root swap adds the read of root and tail entry
// and the write of the root to the end. Emission reads one result from the
// store and pushes it into the output register once that is free, before
// it reads the next, so master stalls hold it back. tready returns as soon
// as the last result has been loaded into the output register, so the next
// set can be loaded while that result waits to be taken.
module heap_sort_engine (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // slave side
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [hse_pkg::DATA_W-1:0] s_axis_tdata_i,  // [31:0] value
  input  logic                       s_axis_tlast_i,  // last_item
  // master side
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [hse_pkg::DATA_W-1:0] m_axis_tdata_o,  // [31:0] sorted_value
  output logic                       m_axis_tlast_o,  // last_result
  output logic                       m_axis_tuser_o   // [0] overflow
);
  import hse_pkg::*;

  mem_req_t          mem_req;
  logic [DATA_W-1:0] rdata_a;
  logic [DATA_W-1:0] rdata_b;
  logic              res_push;
  res_t              res;
  logic              out_free;

  logic              out_valid_q;
  res_t              out_q;

  // output register can take a result when empty or being drained
  assign out_free = !out_valid_q || m_axis_tready_i;

  hse_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  hse_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_value_i (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .out_free_i (out_free),
    .res_push_o (res_push),
    .res_o      (res),
    .mem_req_o  (mem_req),
    .rdata_a_i  (rdata_a),
    .rdata_b_i  (rdata_b)
  );

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_push) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (res_push) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q.data;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tuser_o  = out_q.ovf;

endmodule

// ===== rtl/hse_checker.sv =====
// port-level checks for heap_sort_engine, bound to the top level
// depends on hse_pkg and heap_sort_engine
module hse_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  input  logic                       s_axis_tready_o,
  input  logic                       s_axis_tlast_i,
  input  logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  input  logic [hse_pkg::DATA_W-1:0] m_axis_tdata_o,
  input  logic                       m_axis_tlast_o,
  input  logic                       m_axis_tuser_o
);
  import hse_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) &&
      $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // closing transaction starts the sort, no more loading
  a_close_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("ready after closing transaction");

  // loading continues until the set is closed
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !s_axis_tlast_i |=> s_axis_tready_o)
    else $error("ready dropped while loading");

  // while loading, only the final result of the previous run can be pending
  a_load_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o && m_axis_tvalid_o |-> m_axis_tlast_o)
    else $error("non-final result pending while loading");

endmodule

bind heap_sort_engine hse_checker u_hse_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
